/* sv/vpdra_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vpdra_pkg
// Shared widths, constants, types and the saturation pressure node table
// for the VPD running average block.
// ----------------------------------------------------------------------------
package vpdra_pkg;

  // Field widths
  localparam int unsigned T_W   = 14;
  localparam int unsigned H_W   = 14;
  localparam int unsigned VPD_W = 15;
  localparam int unsigned TM_W  = 13;
  localparam int unsigned HM_W  = 14;
  localparam int unsigned VM_W  = 15;
  localparam int unsigned TS_W  = 20;
  localparam int unsigned HS_W  = 20;
  localparam int unsigned VS_W  = 21;

  // Saturation limits
  localparam int unsigned TS_MAX  = (1 << TS_W) - 1;
  localparam int unsigned HS_MAX  = (1 << HS_W) - 1;
  localparam int unsigned VS_MAX  = (1 << VS_W) - 1;
  localparam int unsigned TM_MAX  = (1 << TM_W) - 1;
  localparam int unsigned HM_MAX  = (1 << HM_W) - 1;
  localparam int unsigned VM_MAX  = (1 << VM_W) - 1;
  localparam int unsigned VPD_MAX = (1 << VPD_W) - 1;

  // Averaging window and its reciprocal (exact floor for sums below 2^21)
  localparam int unsigned WINDOW    = 100;
  localparam int unsigned WIN_W     = $clog2(WINDOW + 1);
  localparam int unsigned MEAN_SH   = 32;
  localparam int unsigned MEAN_RC_W = 32;
  localparam longint unsigned MEAN_RECIP =
    ((64'd1 << MEAN_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);

  // Humidity full scale and its reciprocal (exact floor below 2^30)
  localparam int unsigned HUM_FULL = 10000;
  localparam int unsigned PROD_W   = 30;
  localparam int unsigned VRC_SH   = 43;
  localparam int unsigned VRC_W    = 30;
  localparam longint unsigned VPD_RECIP =
    ((64'd1 << VRC_SH) + 64'(HUM_FULL) - 64'd1) / 64'(HUM_FULL);

  // Curve table geometry; the node spacing is a power of two
  localparam int unsigned CURVE_POINTS = 64;
  localparam int unsigned T_SPAN       = 8192;
  localparam int unsigned STEP         = (T_SPAN + CURVE_POINTS - 1) / CURVE_POINTS;
  localparam int unsigned STEP_W       = $clog2(STEP);
  localparam int unsigned IDX_W        = $clog2(CURVE_POINTS + 1);
  localparam int unsigned ES_W         = 16;

  typedef logic [ES_W-1:0] curve_t [CURVE_POINTS+1];

  // Unsigned restoring division, shift and subtract (elaboration only)
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp() of an unsigned Q16 argument, Q16 result (elaboration only)
  function automatic longint unsigned exp_q16(longint unsigned xq_in);
    longint unsigned xq;
    longint unsigned whole;
    longint unsigned frac;
    longint unsigned term;
    longint unsigned acc;
    xq = xq_in;
    if (xq > ((64'd5 << 16) - 64'd1)) begin
      xq = (64'd5 << 16) - 64'd1;
    end
    case (xq >> 16)
      64'd0:   whole = 64'd65536;
      64'd1:   whole = 64'd178145;
      64'd2:   whole = 64'd484249;
      64'd3:   whole = 64'd1316326;
      default: whole = 64'd3578144;
    endcase
    frac = (xq & 64'hFFFF) << 16;
    term = 64'd1 << 32;
    acc  = term;
    for (int k = 1; k <= 16; k++) begin
      term = udiv64((term * frac) >> 32, 64'(k));
      acc  = acc + term;
    end
    return (whole * acc) >> 32;
  endfunction

  // Node pressures in Pa on the Tetens curve (elaboration only)
  function automatic curve_t build_curve();
    curve_t          c;
    longint unsigned tn;
    longint unsigned xq;
    longint unsigned e;
    for (int i = 0; i <= int'(CURVE_POINTS); i++) begin
      tn   = 64'(i) * 64'(STEP);
      xq   = udiv64(64'd1727 * tn * 64'd65536, 64'd100 * (tn + 64'd23730));
      e    = exp_q16(xq);
      c[i] = ES_W'(udiv64(64'd6108 * e + 64'd327680, 64'd655360));
    end
    return c;
  endfunction

  localparam curve_t CURVE = build_curve();

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCALE,
    ST_RECIP,
    ST_ACCUM,
    ST_MEAN_T,
    ST_MEAN_H,
    ST_MEAN_V,
    ST_STORE
  } state_e;

  // Which running sum the shared mean multiplier works on
  typedef enum logic [1:0] {
    MS_TEMP,
    MS_HUM,
    MS_VPD
  } mean_sel_e;

  typedef struct packed {
    logic      load;
    logic      lookup;
    logic      scale;
    logic      recip;
    logic      accum;
    logic      mean_en;
    mean_sel_e mean_sel;
    logic      store;
  } cmd_t;

  typedef struct packed {
    logic sample_ok;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

/* sv/vpdra_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vpdra_in_if
// Sample channel: temperature and humidity with valid/ready.
// ----------------------------------------------------------------------------
interface vpdra_in_if
  import vpdra_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic signed [T_W-1:0] temperature;
  logic        [H_W-1:0] humidity;

  modport source (output valid, output temperature, output humidity, input ready);
  modport sink   (input valid, input temperature, input humidity, output ready);
endinterface
`default_nettype wire

/* sv/vpdra_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vpdra_out_if
// Result channel: current VPD, three running means and the used flag.
// ----------------------------------------------------------------------------
interface vpdra_out_if
  import vpdra_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [VPD_W-1:0] vpd_now;
  logic [TM_W-1:0]  mean_temperature;
  logic [HM_W-1:0]  mean_humidity;
  logic [VM_W-1:0]  mean_vpd;
  logic             sample_used;

  modport source (output valid, output vpd_now, output mean_temperature,
                  output mean_humidity, output mean_vpd, output sample_used,
                  input ready);
  modport sink   (input valid, input vpd_now, input mean_temperature,
                  input mean_humidity, input mean_vpd, input sample_used,
                  output ready);
endinterface
`default_nettype wire

/* sv/vpd_running_average.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vpd_running_average
// Vapour pressure deficit per sample on an interpolated Tetens curve, with
// running averages of temperature, humidity and deficit.
//
//   channel  dir  request contents
//   smp_i    in   temperature (0.01 C, signed), humidity (0.01 %)
//   res_o    out  vpd_now, mean_temperature, mean_humidity, mean_vpd,
//                 sample_used
//
// A usable sample passes lookup, scale, divide, sum update, three means on one
// shared multiplier and store into the output register; an unusable one goes
// from lookup straight to store. The next request is taken in the idle state after.
// One request is in flight at a time; smp_i.ready is high only when idle.
// A held result does not block acceptance; only the final store waits for it.
// Reset clears the running sums, means, seeded flag and all handshakes.
// ----------------------------------------------------------------------------
module vpd_running_average
  import vpdra_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  vpdra_in_if.sink    smp_i,
  vpdra_out_if.source res_o
);

  cmd_t    cmd;
  status_t status;

  vpdra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (smp_i.valid),
    .in_ready_o (smp_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  vpdra_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .temperature_i      (smp_i.temperature),
    .humidity_i         (smp_i.humidity),
    .out_ready_i        (res_o.ready),
    .out_valid_o        (res_o.valid),
    .vpd_now_o          (res_o.vpd_now),
    .mean_temperature_o (res_o.mean_temperature),
    .mean_humidity_o    (res_o.mean_humidity),
    .mean_vpd_o         (res_o.mean_vpd),
    .sample_used_o      (res_o.sample_used)
  );

endmodule
`default_nettype wire

/* sv/vpdra_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vpdra_ctrl
// Sequencer: walks one sample through lookup, scaling, reciprocal divide, sum
// update, three means (unusable ones skip to store), then the output register.
// ----------------------------------------------------------------------------
module vpdra_ctrl
  import vpdra_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_LOOKUP;
      ST_LOOKUP: state_d = status_i.sample_ok ? ST_SCALE : ST_STORE;
      ST_SCALE:  state_d = ST_RECIP;
      ST_RECIP:  state_d = ST_ACCUM;
      ST_ACCUM:  state_d = ST_MEAN_T;
      ST_MEAN_T: state_d = ST_MEAN_H;
      ST_MEAN_H: state_d = ST_MEAN_V;
      ST_MEAN_V: state_d = ST_STORE;
      ST_STORE:  if (status_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_LOOKUP: cmd_o.lookup = 1'b1;
      ST_SCALE:  cmd_o.scale  = 1'b1;
      ST_RECIP:  cmd_o.recip  = 1'b1;
      ST_ACCUM:  cmd_o.accum  = 1'b1;
      ST_MEAN_T: begin
        cmd_o.mean_en  = 1'b1;
        cmd_o.mean_sel = MS_TEMP;
      end
      ST_MEAN_H: begin
        cmd_o.mean_en  = 1'b1;
        cmd_o.mean_sel = MS_HUM;
      end
      ST_MEAN_V: begin
        cmd_o.mean_en  = 1'b1;
        cmd_o.mean_sel = MS_VPD;
      end
      ST_STORE:  cmd_o.store = status_i.out_free;
      default:   cmd_o = '0;
    endcase
  end

  // A new request always starts with the table lookup
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_LOOKUP))
    else $error("accepted request did not start lookup");

  // Result is only written when the output register can take it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.store |-> status_i.out_free)
    else $error("store issued while output held");

  // A blocked store keeps waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_STORE) && !status_i.out_free) |=> (state_q == ST_STORE))
    else $error("store left before the output register was free");

endmodule
`default_nettype wire

/* sv/vpdra_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vpdra_dp
// Datapath: curve interpolation, deficit product, divide by full scale via
// reciprocal, running sums and a shared reciprocal multiplier for the means.
// ----------------------------------------------------------------------------
module vpdra_dp
  import vpdra_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cmd_t                  cmd_i,
  output status_t                    status_o,
  input  wire logic signed [T_W-1:0] temperature_i,
  input  wire logic        [H_W-1:0] humidity_i,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output logic [VPD_W-1:0]           vpd_now_o,
  output logic [TM_W-1:0]            mean_temperature_o,
  output logic [HM_W-1:0]            mean_humidity_o,
  output logic [VM_W-1:0]            mean_vpd_o,
  output logic                       sample_used_o
);

  // Captured request
  logic signed [T_W-1:0] t_q;
  logic [H_W-1:0]        h_q;
  logic                  ok_q;
  logic [TM_W-1:0]       t_mag;

  // Working registers
  logic [ES_W-1:0]   es_q;
  logic [H_W-1:0]    wt_q;
  logic [PROD_W-1:0] prod_q;
  logic [VPD_W-1:0]  vpd_q;

  // State
  logic [TS_W-1:0] ts_q;
  logic [HS_W-1:0] hs_q;
  logic [VS_W-1:0] vs_q;
  logic [TM_W-1:0] tm_q;
  logic [HM_W-1:0] hm_q;
  logic [VM_W-1:0] vm_q;
  logic            seeded_q;

  // Output register
  logic             out_valid_q;
  logic [VPD_W-1:0] o_vpd_q;
  logic [TM_W-1:0]  o_tm_q;
  logic [HM_W-1:0]  o_hm_q;
  logic [VM_W-1:0]  o_vm_q;
  logic             o_used_q;

  assign t_mag = t_q[TM_W-1:0];

  assign status_o.sample_ok = ok_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      t_q <= temperature_i;
      h_q <= humidity_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= 1'b0;
    end else if (cmd_i.load) begin
      ok_q <= !temperature_i[T_W-1] && (temperature_i != '0) && (humidity_i != '0);
    end
  end

  // Table lookup and linear interpolation
  logic [IDX_W-1:0]       idx_raw, idx;
  logic [STEP_W:0]        rem;
  logic [ES_W-1:0]        node_lo, node_hi, delta;
  logic [ES_W+STEP_W:0]   interp;
  logic [ES_W-1:0]        es_d;
  logic [H_W-1:0]         hum_clip;

  always_comb begin
    idx_raw = IDX_W'(t_mag >> STEP_W);
    idx     = idx_raw;
    rem     = {1'b0, t_mag[STEP_W-1:0]};
    if (idx_raw >= IDX_W'(CURVE_POINTS)) begin
      idx = IDX_W'(CURVE_POINTS - 1);
      rem = (STEP_W+1)'(STEP);
    end
    node_lo  = CURVE[idx];
    node_hi  = CURVE[IDX_W'(idx + 1'b1)];
    delta    = (node_hi > node_lo) ? node_hi - node_lo : '0;
    interp   = delta * rem;
    es_d     = node_lo + ES_W'(interp >> STEP_W);
    hum_clip = (h_q > H_W'(HUM_FULL)) ? H_W'(HUM_FULL) : h_q;
  end

  // Deficit: es * (full - rh), then divide by full scale via reciprocal
  logic [PROD_W+VRC_W-1:0] recip_full;
  logic [PROD_W+VRC_W-VRC_SH-1:0] vpd_raw;

  assign recip_full = prod_q * VRC_W'(VPD_RECIP);
  assign vpd_raw    = recip_full[PROD_W+VRC_W-1:VRC_SH];

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      es_q <= es_d;
      wt_q <= H_W'(HUM_FULL) - hum_clip;
    end
    if (cmd_i.scale) begin
      prod_q <= es_q * wt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vpd_q <= '0;
    end else if (cmd_i.recip) begin
      vpd_q <= (vpd_raw > VPD_MAX) ? VPD_W'(VPD_MAX) : VPD_W'(vpd_raw);
    end
  end

  // Running sums: seed at WINDOW times the value, else sum - mean + x
  logic [TM_W+WIN_W-1:0]  seed_t;
  logic [HM_W+WIN_W-1:0]  seed_h;
  logic [VPD_W+WIN_W-1:0] seed_v;
  logic [TS_W:0]          adv_t;
  logic [HS_W:0]          adv_h;
  logic [VS_W:0]          adv_v;
  logic [TS_W-1:0]        ts_d;
  logic [HS_W-1:0]        hs_d;
  logic [VS_W-1:0]        vs_d;

  always_comb begin
    seed_t = t_mag * WIN_W'(WINDOW);
    seed_h = h_q * WIN_W'(WINDOW);
    seed_v = vpd_q * WIN_W'(WINDOW);
    adv_t  = (ts_q >= TS_W'(tm_q)) ? {1'b0, ts_q - TS_W'(tm_q)} : '0;
    adv_h  = (hs_q >= HS_W'(hm_q)) ? {1'b0, hs_q - HS_W'(hm_q)} : '0;
    adv_v  = (vs_q >= VS_W'(vm_q)) ? {1'b0, vs_q - VS_W'(vm_q)} : '0;
    adv_t  = adv_t + (TS_W+1)'(t_mag);
    adv_h  = adv_h + (HS_W+1)'(h_q);
    adv_v  = adv_v + (VS_W+1)'(vpd_q);
    if (!seeded_q) begin
      ts_d = (seed_t > TS_MAX) ? TS_W'(TS_MAX) : TS_W'(seed_t);
      hs_d = (seed_h > HS_MAX) ? HS_W'(HS_MAX) : HS_W'(seed_h);
      vs_d = (seed_v > VS_MAX) ? VS_W'(VS_MAX) : VS_W'(seed_v);
    end else begin
      ts_d = (adv_t > TS_MAX) ? TS_W'(TS_MAX) : TS_W'(adv_t);
      hs_d = (adv_h > HS_MAX) ? HS_W'(HS_MAX) : HS_W'(adv_h);
      vs_d = (adv_v > VS_MAX) ? VS_W'(VS_MAX) : VS_W'(adv_v);
    end
  end

  // Shared mean unit: sum * reciprocal of WINDOW, then saturate
  logic [VS_W-1:0]           mean_arg;
  logic [VS_W+MEAN_RC_W-1:0] mean_full;
  logic [VS_W-1:0]           mean_quo;

  always_comb begin
    case (cmd_i.mean_sel)
      MS_TEMP: mean_arg = VS_W'(ts_q);
      MS_HUM:  mean_arg = VS_W'(hs_q);
      default: mean_arg = vs_q;
    endcase
    mean_full = mean_arg * MEAN_RC_W'(MEAN_RECIP);
    mean_quo  = VS_W'(mean_full >> MEAN_SH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q     <= '0;
      hs_q     <= '0;
      vs_q     <= '0;
      tm_q     <= '0;
      hm_q     <= '0;
      vm_q     <= '0;
      seeded_q <= 1'b0;
    end else begin
      if (cmd_i.accum) begin
        ts_q     <= ts_d;
        hs_q     <= hs_d;
        vs_q     <= vs_d;
        seeded_q <= 1'b1;
      end
      if (cmd_i.mean_en) begin
        case (cmd_i.mean_sel)
          MS_TEMP: tm_q <= (mean_quo > TM_MAX) ? TM_W'(TM_MAX) : TM_W'(mean_quo);
          MS_HUM:  hm_q <= (mean_quo > HM_MAX) ? HM_W'(HM_MAX) : HM_W'(mean_quo);
          default: vm_q <= (mean_quo > VM_MAX) ? VM_W'(VM_MAX) : VM_W'(mean_quo);
        endcase
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.store) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      o_vpd_q  <= ok_q ? vpd_q : '0;
      o_tm_q   <= tm_q;
      o_hm_q   <= hm_q;
      o_vm_q   <= vm_q;
      o_used_q <= ok_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign vpd_now_o          = o_vpd_q;
  assign mean_temperature_o = o_tm_q;
  assign mean_humidity_o    = o_hm_q;
  assign mean_vpd_o         = o_vm_q;
  assign sample_used_o      = o_used_q;

  // Seeding happens only through a sum update
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(seeded_q) |-> $past(cmd_i.accum))
    else $error("seeded flag set outside sum update");

  // Sums are only touched for a usable sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accum |-> ok_q)
    else $error("sum update on unusable sample");

  // A sample that was not used reports no deficit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (o_used_q || (o_vpd_q == '0)))
    else $error("deficit reported for unused sample");

endmodule
`default_nettype wire

/* tb/vpd_running_average_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpd_running_average_checker
// Watches the sample and result channels of the VPD running average block.
// It keeps its own copy of the running sums and means, works out the result
// of every accepted sample and compares each accepted result, field by field,
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module vpd_running_average_checker
  import vpdra_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  vpdra_in_if       smp_i,
  vpdra_out_if      res_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        checked_o,
  output int        used_o
);

  typedef struct packed {
    logic [VPD_W-1:0] vpd_now;
    logic [TM_W-1:0]  mean_t;
    logic [HM_W-1:0]  mean_h;
    logic [VM_W-1:0]  mean_v;
    logic             used;
  } vpd_result_t;

  // Saturation pressure at each curve node, in Pa
  longint unsigned node_pa [CURVE_POINTS+1];

  // Mirror of the block's averaging state
  logic [TS_W-1:0] temp_acc  = '0;
  logic [HS_W-1:0] hum_acc   = '0;
  logic [VS_W-1:0] vpd_acc   = '0;
  logic [TM_W-1:0] temp_avg  = '0;
  logic [HM_W-1:0] hum_avg   = '0;
  logic [VM_W-1:0] vpd_avg   = '0;
  logic            primed    = 1'b0;

  vpd_result_t expected_results [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
    used_o       = 0;
  end

  // e^x for x in unsigned Q16: whole part from a table, fraction by Taylor sum
  function automatic longint unsigned q16_exp(longint unsigned x);
    longint unsigned arg;
    longint unsigned whole_part;
    longint unsigned frac_q32;
    longint unsigned term;
    longint unsigned series;
    arg = x;
    if (arg > (64'd5 << 16) - 64'd1) begin
      arg = (64'd5 << 16) - 64'd1;
    end
    case (arg >> 16)
      64'd0:   whole_part = 64'd65536;
      64'd1:   whole_part = 64'd178145;
      64'd2:   whole_part = 64'd484249;
      64'd3:   whole_part = 64'd1316326;
      default: whole_part = 64'd3578144;
    endcase
    frac_q32 = (arg & 64'hFFFF) << 16;
    term     = 64'd1 << 32;
    series   = term;
    for (int k = 1; k <= 16; k++) begin
      term   = ((term * frac_q32) >> 32) / 64'(k);
      series = series + term;
    end
    return (whole_part * series) >> 32;
  endfunction

  // Tetens pressure at node n, rounded to the nearest pascal
  function automatic longint unsigned tetens_node(int unsigned n);
    longint unsigned tn;
    longint unsigned xq;
    tn = 64'(n) * 64'(STEP);
    xq = (64'd1727 * tn * 64'd65536) / (64'd100 * (tn + 64'd23730));
    return (64'd6108 * q16_exp(xq) + 64'd327680) / 64'd655360;
  endfunction

  initial begin
    for (int n = 0; n <= int'(CURVE_POINTS); n++) begin
      node_pa[n] = tetens_node(n);
    end
  end

  // Interpolated saturation pressure between the two enclosing nodes
  function automatic longint unsigned sat_pressure(int unsigned t);
    int unsigned     idx;
    int unsigned     frac;
    longint unsigned lo;
    longint unsigned hi;
    idx  = t / STEP;
    frac = t % STEP;
    if (idx >= CURVE_POINTS) begin
      idx  = CURVE_POINTS - 1;
      frac = STEP;
    end
    lo = node_pa[idx];
    hi = node_pa[idx+1];
    if (hi < lo) begin
      hi = lo;
    end
    return lo + ((hi - lo) * 64'(frac)) / 64'(STEP);
  endfunction

  function automatic longint unsigned clip(longint unsigned v, longint unsigned lim);
    return (v > lim) ? lim : v;
  endfunction

  // One step of a running sum: drop one mean's worth, add the new value
  function automatic longint unsigned roll(longint unsigned acc, longint unsigned avg,
                                           longint unsigned x, longint unsigned lim);
    longint unsigned rest;
    rest = (acc >= avg) ? acc - avg : 64'd0;
    return clip(rest + x, lim);
  endfunction

  // Result of one sample; updates the mirrored state as the block would
  function automatic vpd_result_t predict_sample(logic [T_W-1:0] t_bits,
                                                 logic [H_W-1:0] h_bits);
    vpd_result_t     r;
    int unsigned     t_val;
    int unsigned     h_val;
    int unsigned     h_eff;
    longint unsigned deficit;
    r     = '0;
    t_val = t_bits;
    h_val = h_bits;
    if (!t_bits[T_W-1] && t_val != 0 && h_val != 0) begin
      // humidity above full scale counts as saturated air for the deficit
      h_eff   = (h_val > HUM_FULL) ? HUM_FULL : h_val;
      deficit = clip(sat_pressure(t_val) * 64'(HUM_FULL - h_eff) / 64'(HUM_FULL),
                     VPD_MAX);
      r.vpd_now = VPD_W'(deficit);
      r.used    = 1'b1;
      if (!primed) begin
        temp_acc = TS_W'(clip(64'(WINDOW) * t_val, TS_MAX));
        hum_acc  = HS_W'(clip(64'(WINDOW) * h_val, HS_MAX));
        vpd_acc  = VS_W'(clip(64'(WINDOW) * deficit, VS_MAX));
        primed   = 1'b1;
      end else begin
        temp_acc = TS_W'(roll(temp_acc, temp_avg, t_val, TS_MAX));
        hum_acc  = HS_W'(roll(hum_acc, hum_avg, h_val, HS_MAX));
        vpd_acc  = VS_W'(roll(vpd_acc, vpd_avg, deficit, VS_MAX));
      end
      temp_avg = TM_W'(clip(64'(temp_acc) / 64'(WINDOW), TM_MAX));
      hum_avg  = HM_W'(clip(64'(hum_acc) / 64'(WINDOW), HM_MAX));
      vpd_avg  = VM_W'(clip(64'(vpd_acc) / 64'(WINDOW), VM_MAX));
    end
    r.mean_t = temp_avg;
    r.mean_h = hum_avg;
    r.mean_v = vpd_avg;
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      fail_count_o++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Compare results first, then record the new sample's prediction
  always @(posedge clk_i or negedge rst_ni) begin
    vpd_result_t want;
    if (!rst_ni) begin
      temp_acc = '0;
      hum_acc  = '0;
      vpd_acc  = '0;
      temp_avg = '0;
      hum_avg  = '0;
      vpd_avg  = '0;
      primed   = 1'b0;
      expected_results.delete();
      pending_o = 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        checked_o++;
        if (res_i.sample_used === 1'b1) begin
          used_o++;
        end
        if (expected_results.size() == 0) begin
          fail_count_o++;
          $display("%0t ns: result with nothing expected, expected none, got vpd %0d",
                   $time, res_i.vpd_now);
        end else begin
          want = expected_results.pop_front();
          check_field("vpd_now", 16'(want.vpd_now), 16'(res_i.vpd_now));
          check_field("mean_temperature", 16'(want.mean_t), 16'(res_i.mean_temperature));
          check_field("mean_humidity", 16'(want.mean_h), 16'(res_i.mean_humidity));
          check_field("mean_vpd", 16'(want.mean_v), 16'(res_i.mean_vpd));
          check_field("sample_used", 16'(want.used), 16'(res_i.sample_used));
        end
      end
      if (smp_i.valid && smp_i.ready) begin
        expected_results.push_back(predict_sample(smp_i.temperature, smp_i.humidity));
      end
      pending_o = expected_results.size();
    end
  end

endmodule

/* tb/vpd_running_average_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpd_running_average_tb
// Drives samples into the VPD running average block and lets the checker
// judge every result. A directed set covers the field extremes, invalid
// samples, curve node edges and over-range humidity; stretches of hot wet
// and hot dry air push the running sums into saturation; the rest is random.
// ----------------------------------------------------------------------------
module vpd_running_average_tb;
  import vpdra_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int N_RANDOM     = 480;
  localparam int N_WET        = 150;
  localparam int N_DRY        = 100;
  localparam int SETTLE_TICKS = 20;

  typedef enum int {
    RX_OPEN,
    RX_RANDOM,
    RX_HOLDS
  } rx_mode_e;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  vpdra_in_if  smp_if ();
  vpdra_out_if res_if ();

  int fails;
  int pending;
  int checked;
  int used_cnt;
  int sent       = 0;
  int burst_left = 0;
  int cycles     = 0;

  rx_mode_e rx_mode   = RX_OPEN;
  int       mode_left = 0;
  int       hold_left = 0;

  vpd_running_average dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .smp_i  (smp_if),
    .res_o  (res_if)
  );

  vpd_running_average_checker chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .smp_i        (smp_if),
    .res_i        (res_if),
    .fail_count_o (fails),
    .pending_o    (pending),
    .checked_o    (checked),
    .used_o       (used_cnt)
  );

  always begin
    #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding", cycles, pending);
      $display("** vpd_running_average: FAILED **");
      $finish;
    end
  end

  // Result back-pressure: modes of open, random and long holds
  always @(negedge clk) begin
    if (mode_left == 0) begin
      rx_mode   = rx_mode_e'($urandom_range(0, 2));
      mode_left = $urandom_range(20, 200);
    end
    mode_left--;
    case (rx_mode)
      RX_OPEN: begin
        res_if.ready <= 1'b1;
      end
      RX_RANDOM: begin
        res_if.ready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        if (hold_left > 0) begin
          hold_left--;
          res_if.ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          hold_left = $urandom_range(1, 24);
          res_if.ready <= 1'b0;
        end else begin
          res_if.ready <= 1'b1;
        end
      end
    endcase
  end

  // Sender idle, with junk on the payload
  task automatic tx_idle(int n);
    repeat (n) begin
      @(negedge clk);
      smp_if.valid       <= 1'b0;
      smp_if.temperature <= T_W'($urandom);
      smp_if.humidity    <= H_W'($urandom);
    end
  endtask

  // Present one request and hold it until it is taken
  task automatic send_sample(int t, int h);
    if (burst_left == 0) begin
      tx_idle($urandom_range(1, 12));
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk);
    smp_if.valid       <= 1'b1;
    smp_if.temperature <= T_W'(t);
    smp_if.humidity    <= H_W'(h);
    @(posedge clk);
    while (!smp_if.ready) begin
      @(posedge clk);
    end
    sent++;
  endtask

  // Hold off until every outstanding result has been returned
  task automatic drain();
    tx_idle(1);
    while (pending != 0) begin
      @(negedge clk);
    end
  endtask

  // Mostly plausible readings, some invalid ones and some raw noise
  task automatic random_sample();
    int pick;
    int t;
    int h;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      t = $urandom_range(0, 16383);
      h = $urandom_range(0, 16383);
    end else if (pick < 20) begin
      case ($urandom_range(0, 2))
        0: begin t = -$urandom_range(1, 8192); h = $urandom_range(0, 16383); end
        1: begin t = 0;                         h = $urandom_range(0, 16383); end
        default: begin t = $urandom_range(1, 8191); h = 0; end
      endcase
    end else begin
      t = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8191) : $urandom_range(1, 6000);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(10001, 16383)
                                      : $urandom_range(1, 10000);
    end
    send_sample(t, h);
  endtask

  initial begin
    int dir_t [20] = '{0, -1, -8192, 2500, 8191, 8191, 1, 127, 128, 8064,
                       0, -4000, 6000, 5461, 2730, 4096, 300, 8191, 1, 8190};
    int dir_h [20] = '{0, 5000, 16383, 0, 1, 16383, 1, 10000, 9999, 5000,
                       10000, 8000, 3000, 10922, 5461, 10001, 16383, 0, 16383, 2};

    smp_if.valid       = 1'b0;
    smp_if.temperature = '0;
    smp_if.humidity    = '0;
    res_if.ready       = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Invalid samples before seeding, then the seed and the edge cases
    foreach (dir_t[i]) begin
      send_sample(dir_t[i], dir_h[i]);
    end
    drain();

    // Hot and over-range wet: humidity sum runs into its ceiling
    repeat (N_WET) begin
      send_sample($urandom_range(7000, 8191), $urandom_range(15000, 16383));
    end
    // Hot and dry: deficit clips and its sum saturates
    repeat (N_DRY) begin
      send_sample($urandom_range(7500, 8191), $urandom_range(1, 300));
    end
    drain();

    for (int n = 0; n < N_RANDOM; n++) begin
      random_sample();
      if (n == N_RANDOM / 2) begin
        drain();
      end
    end

    drain();
    tx_idle(SETTLE_TICKS);

    $display("Covered %0d samples: directed edges, saturating wet and dry stretches, random mix",
             sent);
    $display("%0d results checked, %0d updated the averages, %0d mismatches",
             checked, used_cnt, fails);
    if (fails == 0) begin
      $display("** vpd_running_average: PASSED **");
    end else begin
      $display("** vpd_running_average: FAILED **");
    end
    $finish;
  end

endmodule
